>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SKS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/skset_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skset_pkg;

    localparam int CAPACITY   = 1024;
    localparam int KEY_WIDTH  = 32;
    localparam int COUNT_W    = 11;
    localparam int GROUP      = 32;
    localparam int NUM_GROUPS = CAPACITY / GROUP;

    localparam logic [1:0] ACT_SEARCH = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    typedef logic signed [KEY_WIDTH-1:0] t_key;

    typedef struct packed {
        logic [1:0] action;
        t_key       key;
    } t_in;

    typedef struct packed {
        logic               success;
        logic               set_full;
        logic [COUNT_W-1:0] entry_count;
    } t_out;

    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic del_en;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> rtl/sorted_key_set.sv
`timescale 1ns / 1ps
`default_nettype none
// Sorted key set: holds up to CAPACITY distinct signed keys in ascending
// order in a row of cells, one key per cell, each cell taking keys only from
// its two neighbors and the broadcast command key.
// Command channel: drive i_in (action and key) with start high; the beat is
// taken at a rising edge where busy is low. Actions are search, insert and
// delete; the unused code leaves the set untouched.
// Result channel: o_done is high for exactly one cycle with o_result holding
// success, set_full and the entry count after the operation.
// Operation: after the accepting edge the cells compare their keys in the
// compare state, the match flags are reduced by a registered OR tree in the
// reduce state, and the cells shift in the update state.
// A new command is taken only in the idle or update state: busy drops in the
// cycle before the result is shown, so the next command may be taken at the
// edge that raises o_done.
// Reset clears the entry count and the control state; cell contents are
// meaningless until written. The receiver cannot stall: the result is shown
// once and must be taken.
`include "assert_macros.svh"

module sorted_key_set (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    input  skset_pkg::t_in    i_in,
    output logic              busy,
    output logic              o_done,
    output skset_pkg::t_out   o_result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_RED  = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]                         r_state;
    logic [1:0]                         n_state;
    logic [1:0]                         r_action;
    skset_pkg::t_key                    r_key;
    logic [skset_pkg::COUNT_W-1:0]      r_count;
    logic [skset_pkg::COUNT_W-1:0]      n_count;
    logic                               r_done;
    skset_pkg::t_out                    r_result;
    skset_pkg::t_out                    n_result;

    logic                               accept;
    logic                               found;
    logic                               full;
    logic                               do_ins;
    logic                               do_del;
    skset_pkg::t_cell_ctl               ctl;

    skset_pkg::t_key                    w_keys [skset_pkg::CAPACITY];
    logic [skset_pkg::CAPACITY-1:0]     w_lt;
    logic [skset_pkg::CAPACITY-1:0]     w_eq;
    logic [skset_pkg::CAPACITY-1:0]     w_valid;
    logic [skset_pkg::NUM_GROUPS-1:0]   w_group_eq;

    assign busy   = r_state inside {ST_CMP, ST_RED};
    assign accept = start && !busy;

    assign found  = |w_group_eq;
    assign full   = (r_count == skset_pkg::COUNT_W'(skset_pkg::CAPACITY));
    assign do_ins = (r_state == ST_UPD) && (r_action == skset_pkg::ACT_INSERT)
                    && !found && !full;
    assign do_del = (r_state == ST_UPD) && (r_action == skset_pkg::ACT_DELETE)
                    && found;

    assign ctl.cmp_en = (r_state == ST_CMP);
    assign ctl.ins_en = do_ins;
    assign ctl.del_en = do_del;

    genvar g;
    generate
        for (g = 0; g < skset_pkg::CAPACITY; g++) begin : g_cell
            skset_pkg::t_key left_key;
            skset_pkg::t_key right_key;
            logic            left_lt;

            assign w_valid[g] = skset_pkg::COUNT_W'(g) < r_count;

            if (g == 0) begin : g_first
                assign left_key = r_key;
                assign left_lt  = 1'b1;
            end else begin : g_inner
                assign left_key = w_keys[g-1];
                assign left_lt  = w_lt[g-1];
            end

            if (g == skset_pkg::CAPACITY - 1) begin : g_last
                assign right_key = w_keys[g];
            end else begin : g_body
                assign right_key = w_keys[g+1];
            end

            skset_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_key       (r_key),
                .i_valid     (w_valid[g]),
                .i_left_key  (left_key),
                .i_left_lt   (left_lt),
                .i_right_key (right_key),
                .o_key       (w_keys[g]),
                .o_lt        (w_lt[g]),
                .o_eq        (w_eq[g])
            );
        end

        for (g = 0; g < skset_pkg::NUM_GROUPS; g++) begin : g_grp
            skset_group_or u_or (
                .i_clk  (i_clk),
                .i_en   (r_state == ST_RED),
                .i_bits (w_eq[g*skset_pkg::GROUP +: skset_pkg::GROUP]),
                .o_any  (w_group_eq[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP:  n_state = ST_RED;
            ST_RED:  n_state = ST_UPD;
            ST_UPD: begin
                n_state = accept ? ST_CMP : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + skset_pkg::COUNT_W'(1);
        end else if (do_del) begin
            n_count = r_count - skset_pkg::COUNT_W'(1);
        end
        n_result.success = do_ins || do_del
                           || ((r_action == skset_pkg::ACT_SEARCH) && found);
        n_result.set_full = (r_action == skset_pkg::ACT_INSERT) && !found && full;
        n_result.entry_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= (r_state == ST_UPD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_in.action;
            r_key    <= i_in.key;
        end
        if (r_state == ST_UPD) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `SKS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= skset_pkg::COUNT_W'(skset_pkg::CAPACITY))
    `SKS_ASSERT_NXT(a_done_after_upd, i_clk, i_rst_n, r_state == ST_UPD, o_done)
    `SKS_ASSERT_IMP(a_full_flag, i_clk, i_rst_n, o_done && o_result.set_full,
        !o_result.success
        && o_result.entry_count == skset_pkg::COUNT_W'(skset_pkg::CAPACITY))
    `SKS_ASSERT_IMP(a_count_moves_on_upd, i_clk, i_rst_n, r_count != $past(r_count),
        $past(r_state) == ST_UPD)

endmodule

`default_nettype wire

>>> rtl/skset_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module skset_cell (
    input  wire                 i_clk,
    input  skset_pkg::t_cell_ctl i_ctl,
    input  skset_pkg::t_key     i_key,
    input  wire                 i_valid,
    input  skset_pkg::t_key     i_left_key,
    input  wire                 i_left_lt,
    input  skset_pkg::t_key     i_right_key,
    output skset_pkg::t_key     o_key,
    output logic                o_lt,
    output logic                o_eq
);

    skset_pkg::t_key r_key;
    skset_pkg::t_key n_key;
    logic            r_lt;
    logic            r_eq;

    // A cell whose key is not below the search key moves: on insert it takes
    // the new key at the boundary or its left neighbor's key past it; on
    // delete it takes its right neighbor's key.
    always_comb begin
        n_key = r_key;
        if (i_ctl.ins_en && !r_lt) begin
            n_key = i_left_lt ? i_key : i_left_key;
        end else if (i_ctl.del_en && !r_lt) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (i_ctl.cmp_en) begin
            r_lt <= i_valid && (r_key < i_key);
            r_eq <= i_valid && (r_key == i_key);
        end
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

`default_nettype wire

>>> rtl/skset_group_or.sv
`timescale 1ns / 1ps
`default_nettype none

module skset_group_or (
    input  wire                         i_clk,
    input  wire                         i_en,
    input  wire [skset_pkg::GROUP-1:0]  i_bits,
    output logic                        o_any
);

    logic r_any;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_any <= |i_bits;
        end
    end

    assign o_any = r_any;

endmodule

`default_nettype wire

>>> sim/tb_sorted_key_set.sv
`timescale 1ns / 1ps

module tb_sorted_key_set;
    import skset_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam t_key KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
    localparam t_key KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_in  i_in;
    logic busy;
    logic o_done;
    t_out o_result;

    sorted_key_set uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_in     (i_in),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Keys held by the set, kept in ascending signed order.
    t_key held_keys[$];
    t_out expected_results[$];
    int   n_errors;
    int   calm_left;

    // Applies one command to the local copy of the set and returns the result.
    function automatic t_out apply_command(t_in cmd);
        int   pos;
        bit   found;
        t_out res;
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] < cmd.key)
            pos++;
        found = (pos < held_keys.size()) && (held_keys[pos] == cmd.key);
        res = '0;
        case (cmd.action)
            ACT_SEARCH: begin
                res.success = found;
            end
            ACT_INSERT: begin
                if (!found) begin
                    if (held_keys.size() >= CAPACITY) begin
                        res.set_full = 1'b1;
                    end else begin
                        held_keys.insert(pos, cmd.key);
                        res.success = 1'b1;
                    end
                end
            end
            ACT_DELETE: begin
                if (found) begin
                    held_keys.delete(pos);
                    res.success = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.entry_count = COUNT_W'(held_keys.size());
        return res;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 63) == 0) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic t_key rand_key();
        return t_key'($urandom);
    endfunction

    function automatic t_key held_or_rand_key();
        if (held_keys.size() == 0)
            return rand_key();
        return held_keys[$urandom_range(0, held_keys.size() - 1)];
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_cmd(input logic [1:0] act, input t_key k);
        int  gap;
        t_in cmd;
        gap = pick_gap();
        cmd.action = act;
        cmd.key = k;
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_in = cmd;
        do begin
            @(posedge i_clk);
        end while (busy);
        expected_results.push_back(apply_command(cmd));
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        start = 1'b0;
        while (expected_results.size() > 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: success %0b set_full %0b entry_count %0d",
                       o_result.success, o_result.set_full, o_result.entry_count);
                n_errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_result.success !== exp_r.success) begin
                    $error("success: expected %0b, got %0b", exp_r.success,
                           o_result.success);
                    n_errors++;
                end
                if (o_result.set_full !== exp_r.set_full) begin
                    $error("set_full: expected %0b, got %0b", exp_r.set_full,
                           o_result.set_full);
                    n_errors++;
                end
                if (o_result.entry_count !== exp_r.entry_count) begin
                    $error("entry_count: expected %0d, got %0d", exp_r.entry_count,
                           o_result.entry_count);
                    n_errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_cmd(ACT_SEARCH, 0);
        send_cmd(ACT_DELETE, 5);
        send_cmd(ACT_UNUSED, -1);
        send_cmd(ACT_INSERT, KEY_MIN);
        send_cmd(ACT_INSERT, KEY_MAX);
        send_cmd(ACT_INSERT, 0);
        send_cmd(ACT_INSERT, KEY_MAX);
        send_cmd(ACT_SEARCH, KEY_MIN);
        send_cmd(ACT_SEARCH, KEY_MAX);
        send_cmd(ACT_SEARCH, -1);
        send_cmd(ACT_UNUSED, KEY_MAX);
        send_cmd(ACT_DELETE, KEY_MIN);
        send_cmd(ACT_DELETE, KEY_MIN);
        send_cmd(ACT_SEARCH, KEY_MIN);
        send_cmd(ACT_INSERT, -1);
        send_cmd(ACT_INSERT, 1);
        send_cmd(ACT_DELETE, KEY_MAX);
        send_cmd(ACT_DELETE, 0);
        send_cmd(ACT_DELETE, -1);
        send_cmd(ACT_DELETE, 1);
        send_cmd(ACT_SEARCH, 1);
    endtask

    // A small pool of keys makes hits, duplicates and re-inserts common.
    task automatic test_small_pool();
        t_key pool[16];
        t_key k;
        int   r;
        pool[0] = KEY_MIN;
        pool[1] = KEY_MIN + 1;
        pool[2] = -2;
        pool[3] = -1;
        pool[4] = 0;
        pool[5] = 1;
        pool[6] = KEY_MAX - 1;
        pool[7] = KEY_MAX;
        for (int i = 8; i < 16; i++)
            pool[i] = rand_key();
        repeat (260) begin
            k = ($urandom_range(0, 4) == 0) ? rand_key() : pool[$urandom_range(0, 15)];
            r = $urandom_range(0, 99);
            if (r < 35)
                send_cmd(ACT_INSERT, k);
            else if (r < 65)
                send_cmd(ACT_DELETE, k);
            else if (r < 92)
                send_cmd(ACT_SEARCH, k);
            else
                send_cmd(ACT_UNUSED, k);
        end
    endtask

    task automatic test_fill_to_capacity();
        int r;
        while (held_keys.size() < CAPACITY) begin
            r = $urandom_range(0, 19);
            if (r < 17)
                send_cmd(ACT_INSERT, rand_key());
            else if (r == 17)
                send_cmd(ACT_SEARCH, held_or_rand_key());
            else if (r == 18)
                send_cmd(ACT_INSERT, held_or_rand_key());
            else
                send_cmd(ACT_SEARCH, rand_key());
        end
    endtask

    // The set starts full here: absent inserts get set_full, present ones fail without it.
    task automatic test_full_set();
        t_key k;
        int   r;
        repeat (40) begin
            r = $urandom_range(0, 9);
            if (r < 3) begin
                send_cmd(ACT_INSERT, rand_key());
            end else if (r < 5) begin
                send_cmd(ACT_INSERT, held_or_rand_key());
            end else if (r < 7) begin
                send_cmd(ACT_SEARCH, held_or_rand_key());
            end else if (r == 7) begin
                send_cmd(ACT_UNUSED, rand_key());
            end else begin
                k = held_or_rand_key();
                send_cmd(ACT_DELETE, k);
                send_cmd(ACT_INSERT, rand_key());
                send_cmd(ACT_INSERT, k);
            end
        end
    endtask

    task automatic test_drain();
        int r;
        repeat (120) begin
            r = $urandom_range(0, 9);
            if (r < 6)
                send_cmd(ACT_DELETE, held_or_rand_key());
            else if (r == 6)
                send_cmd(ACT_DELETE, rand_key());
            else if (r < 9)
                send_cmd(ACT_SEARCH, held_or_rand_key());
            else
                send_cmd(ACT_INSERT, rand_key());
        end
    endtask

    initial begin
        n_errors = 0;
        calm_left = 0;
        start = 1'b0;
        i_in = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        wait_all_results();
        test_small_pool();
        test_fill_to_capacity();
        wait_all_results();
        test_full_set();
        test_drain();
        wait_all_results();

        repeat (10) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("tb_sorted_key_set passed");
        end else begin
            $display("tb_sorted_key_set failed");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("tb_sorted_key_set failed");
        $finish;
    end

endmodule
